// ===== rtl/msl_pkg.sv =====
// Shared types, constants and arithmetic helpers of the multi-stream Lehmer generator.
package msl_pkg;

  localparam int unsigned NumStreams = 256;
  localparam int unsigned IdxW       = 8;
  localparam int unsigned StateW     = 31;
  localparam int unsigned ConstW     = 17;
  localparam int unsigned ProdW      = StateW + ConstW;

  typedef logic [StateW-1:0] state_t;
  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [ConstW-1:0] mulk_t;
  typedef logic [ProdW-1:0]  prod_t;

  localparam state_t LehmerMod     = 31'h7FFF_FFFF;
  localparam mulk_t  LehmerMul     = 17'd48271;
  localparam mulk_t  LehmerJump    = 17'd22925;
  localparam state_t LehmerDefault = 31'd123456789;
  localparam idx_t   LastStream    = idx_t'(NumStreams - 1);

  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_PLANT = 2'd1,
    KIND_INIT  = 2'd2,
    KIND_PUT   = 2'd3
  } kind_t;

  // Datapath operations requested by the controller.
  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_INIT_IN    = 4'd1,
    OP_PUT_IN     = 4'd2,
    OP_PLANT_IN   = 4'd3,
    OP_PLANT_DEF  = 4'd4,
    OP_MUL_PLANT  = 4'd5,
    OP_STEP_PLANT = 4'd6,
    OP_MUL_DRAW   = 4'd7,
    OP_DRAW_WB    = 4'd8,
    OP_PUT_Q      = 4'd9
  } dp_op_t;

  typedef struct packed {
    logic   latch;    // capture the incoming beat's stream and seed
    logic   addr_in;  // read the memory at the incoming stream index
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic plant_last; // plant chain is at the last stream
  } dp_stat_t;

  // Replace a zero seed, or one equal to the modulus, by the default seed.
  function automatic state_t clean_seed(input state_t s);
    state_t r;
    r = s;
    if (s == '0 || s == LehmerMod) begin
      r = LehmerDefault;
    end
    return r;
  endfunction

  // Reduce a product modulo 2^31-1 by two Mersenne folds and one subtract.
  function automatic state_t mers_fold(input prod_t p);
    logic [StateW:0] f1;
    logic [StateW:0] f2;
    f1 = {1'b0, p[StateW-1:0]} + (StateW+1)'(p[ProdW-1:StateW]);
    f2 = {1'b0, f1[StateW-1:0]} + (StateW+1)'(f1[StateW]);
    if (f2 >= {1'b0, LehmerMod}) begin
      f2 = f2 - {1'b0, LehmerMod};
    end
    return f2[StateW-1:0];
  endfunction

endpackage

// ===== rtl/msl_if.sv =====
// Valid/ready stream interfaces for the request and sample channels.
interface msl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  stream;
  logic [30:0] seed_value;

  modport source (output valid, output kind, output stream, output seed_value, input ready);
  modport sink   (input valid, input kind, input stream, input seed_value, output ready);
endinterface

interface msl_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/msl_ctrl.sv =====
// Controller state machine: sequences draws, writes and the plant chain.
module msl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_kind,
  input  logic             in_stream_zero,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  input  msl_pkg::dp_stat_t stat,
  output msl_pkg::dp_cmd_t  cmd
);
  import msl_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PMUL  = 7'b0000010,
    ST_PFOLD = 7'b0000100,
    ST_DADDR = 7'b0001000,
    ST_DMUL  = 7'b0010000,
    ST_DFOLD = 7'b0100000,
    ST_PUTW  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  kind_t  pend;
  logic   planted;
  logic   load_out;
  logic   need_plant;
  kind_t  kind;

  assign kind       = kind_t'(in_kind);
  assign need_plant = !planted && !in_stream_zero;

  always_comb begin
    state_next  = state;
    cmd.latch   = 1'b0;
    cmd.addr_in = 1'b0;
    cmd.op      = OP_NONE;
    in_ready    = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.addr_in = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          unique case (kind)
            KIND_DRAW: begin
              if (need_plant) begin
                cmd.op     = OP_PLANT_DEF;
                state_next = ST_PMUL;
              end else begin
                state_next = ST_DMUL;
              end
            end
            KIND_PLANT: begin
              cmd.op     = OP_PLANT_IN;
              state_next = ST_PMUL;
            end
            KIND_INIT: begin
              cmd.op = OP_INIT_IN;
            end
            KIND_PUT: begin
              if (need_plant) begin
                cmd.op     = OP_PLANT_DEF;
                state_next = ST_PMUL;
              end else begin
                cmd.op = OP_PUT_IN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PMUL: begin
        cmd.op     = OP_MUL_PLANT;
        state_next = ST_PFOLD;
      end
      ST_PFOLD: begin
        cmd.op = OP_STEP_PLANT;
        if (stat.plant_last) begin
          priority if (pend == KIND_DRAW) begin
            state_next = ST_DADDR;
          end else if (pend == KIND_PUT) begin
            state_next = ST_PUTW;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_PMUL;
        end
      end
      ST_DADDR: begin
        state_next = ST_DMUL;
      end
      ST_DMUL: begin
        cmd.op     = OP_MUL_DRAW;
        state_next = ST_DFOLD;
      end
      ST_DFOLD: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.op     = OP_DRAW_WB;
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_PUTW: begin
        cmd.op     = OP_PUT_Q;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      planted   <= 1'b0;
      pend      <= KIND_DRAW;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.latch) begin
        pend <= kind;
      end
      if (cmd.op == OP_PLANT_IN || cmd.op == OP_PLANT_DEF) begin
        planted <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A draw from stream zero never plants, even while unplanted.
  a_draw_zero_direct: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == KIND_DRAW && in_stream_zero) |=> state == ST_DMUL)
    else $error("draw on stream zero did not go straight to multiply");

  // A draw or put on a nonzero stream is never served before planting.
  a_plant_first: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_stream_zero && (kind == KIND_DRAW || kind == KIND_PUT))
    |=> planted)
    else $error("nonzero stream accessed without planting");

  // A finished draw waits while the previous sample is still held.
  a_fold_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DFOLD && out_valid && !out_ready) |=> state == ST_DFOLD)
    else $error("sample register overwritten before it was taken");

endmodule

// ===== rtl/msl_dpath.sv =====
// Datapath: stream state memory, stream zero register, shared multiplier and fold.
module msl_dpath (
  input  logic              clk,
  input  logic              rst,
  input  msl_pkg::dp_cmd_t  cmd,
  output msl_pkg::dp_stat_t stat,
  input  msl_pkg::idx_t     in_stream,
  input  msl_pkg::state_t   in_seed,
  output msl_pkg::state_t   sample
);
  import msl_pkg::*;

  // Entries 1..NumStreams-1 live here; entry 0 is the s0 register.
  state_t mem [NumStreams];
  state_t rd_data;
  idx_t   rd_addr;
  logic   mem_we;
  idx_t   wr_addr;
  state_t wr_data;

  idx_t   idx_q;
  state_t seed_q;
  state_t s0;
  state_t chain;
  idx_t   cnt;
  prod_t  prod;

  state_t in_clean;
  state_t folded;
  state_t operand;
  mulk_t  mulk;
  state_t plant_seed;

  assign in_clean   = clean_seed(in_seed);
  assign folded     = mers_fold(prod);
  assign plant_seed = (cmd.op == OP_PLANT_IN) ? in_clean : LehmerDefault;
  assign rd_addr    = cmd.addr_in ? in_stream : idx_q;
  assign stat.plant_last = (cnt == LastStream);

  always_comb begin
    if (cmd.op == OP_MUL_PLANT) begin
      operand = chain;
      mulk    = LehmerJump;
    end else begin
      operand = (idx_q == '0) ? s0 : rd_data;
      mulk    = LehmerMul;
    end
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = idx_q;
    wr_data = seed_q;
    unique case (cmd.op)
      OP_PUT_IN: begin
        mem_we  = (in_stream != '0);
        wr_addr = in_stream;
        wr_data = in_clean;
      end
      OP_STEP_PLANT: begin
        mem_we  = 1'b1;
        wr_addr = cnt;
        wr_data = folded;
      end
      OP_DRAW_WB: begin
        mem_we  = (idx_q != '0);
        wr_data = folded;
      end
      OP_PUT_Q: begin
        mem_we  = (idx_q != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      idx_q  <= in_stream;
      seed_q <= in_clean;
    end
    prod <= ProdW'(operand) * ProdW'(mulk);
    if (cmd.op == OP_PLANT_IN || cmd.op == OP_PLANT_DEF) begin
      chain <= plant_seed;
      cnt   <= idx_t'(1);
    end else if (cmd.op == OP_STEP_PLANT) begin
      chain <= folded;
      cnt   <= cnt + idx_t'(1);
    end
    if (cmd.op == OP_DRAW_WB) begin
      sample <= folded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0 <= LehmerDefault;
    end else begin
      unique case (cmd.op)
        OP_INIT_IN:   s0 <= in_clean;
        OP_PUT_IN:    if (in_stream == '0) s0 <= in_clean;
        OP_PLANT_IN,
        OP_PLANT_DEF: s0 <= plant_seed;
        OP_DRAW_WB:   if (idx_q == '0) s0 <= folded;
        OP_PUT_Q:     if (idx_q == '0) s0 <= seed_q;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/multi_stream_lehmer_rng_core.sv =====
// Top level of the multi-stream Lehmer (MINSTD 48271) generator, 256 streams.
//
//   channel  | dir | beat payload                         | meaning
//   ---------+-----+--------------------------------------+-----------------------------
//   items    | in  | kind[1:0] stream[7:0] seed_value[30:0]| draw / plant / init / put
//   samples  | out | sample[30:0]                          | new state of the drawn stream
//
// Sequencing: a draw steps through accept and memory read, 31x17 multiply, and Mersenne
// fold and write-back; init and put finish in the accept cycle. A plant runs the
// jump chain through the shared multiplier, a multiply and a fold step per stream.
// A draw or put on a nonzero stream before any plant first runs that chain.
// Reset: rst is synchronous; stream 0 returns to the default seed, the plant flag
// clears. The memory needs no clearing: its entries are never read before a plant.
// Stalls: one sample register parts the sides; a finished draw holds in the fold
// step while the previous sample waits, and items is not ready until it lands.
module multi_stream_lehmer_rng_core (
  input  logic      clk,
  input  logic      rst,
  msl_in_if.sink    items,
  msl_out_if.source samples
);
  import msl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_stream_zero;

  // Stream zero never needs a plant; the controller decides on this bit.
  assign in_stream_zero = (items.stream == '0);

  msl_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (items.valid),
    .in_kind        (items.kind),
    .in_stream_zero (in_stream_zero),
    .in_ready       (items.ready),
    .out_ready      (samples.ready),
    .out_valid      (samples.valid),
    .stat           (stat),
    .cmd            (cmd)
  );

  // Memory, multiplier and fold; advance the chain and write back on command.
  msl_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_stream (items.stream),
    .in_seed   (items.seed_value),
    .sample    (samples.sample)
  );

endmodule

// ===== sim/tb_multi_stream_lehmer_rng_core.sv =====
// Self-checking testbench of the multi-stream Lehmer generator core.
`timescale 1ns / 1ps

module tb_multi_stream_lehmer_rng_core;
  import msl_pkg::*;

  // Cycle budget: every item a full plant chain plus the longest gap and
  // stall still stays well under a third of this.
  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned RandItems  = 750;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned DrainWait  = 600;   // covers a trailing plant chain

  // One row of the directed table. pinned marks rows whose sample is typed in.
  typedef struct packed {
    kind_t  kind;
    idx_t   stream;
    state_t seed;
    logic   pinned;
    state_t sample;
  } req_row_t;

  localparam int NDir = 26;

  // Pinned values: default seed drawn once is 115541394, seed 1 gives the
  // multiplier itself, seed 2^31-2 (minus one) gives the modulus minus 48271.
  localparam req_row_t DirTab [NDir] = '{
    '{KIND_DRAW,  8'd0,   31'd0,          1'b1, 31'd115541394},  // stream 0 out of reset
    '{KIND_INIT,  8'd77,  31'd1,          1'b0, 31'd0},
    '{KIND_DRAW,  8'd0,   31'd0,          1'b1, 31'd48271},
    '{KIND_DRAW,  8'd0,   31'h7FFF_FFFF,  1'b1, 31'd182605794},
    '{KIND_PUT,   8'd0,   31'd2147483646, 1'b0, 31'd0},          // stream 0 keeps unplanted
    '{KIND_DRAW,  8'd0,   31'd0,          1'b1, 31'd2147435376},
    '{KIND_INIT,  8'd255, 31'd0,          1'b0, 31'd0},          // zero seed
    '{KIND_DRAW,  8'd0,   31'd0,          1'b1, 31'd115541394},
    '{KIND_PUT,   8'd0,   31'h7FFF_FFFF,  1'b0, 31'd0},          // seed equal to modulus
    '{KIND_DRAW,  8'd0,   31'd0,          1'b1, 31'd115541394},
    '{KIND_DRAW,  8'd255, 31'h7FFF_FFFF,  1'b0, 31'd0},          // unplanted: chain first
    '{KIND_DRAW,  8'd1,   31'd0,          1'b0, 31'd0},
    '{KIND_DRAW,  8'd0,   31'd0,          1'b1, 31'd115541394},  // chain reseeded stream 0
    '{KIND_PLANT, 8'd255, 31'd1,          1'b0, 31'd0},
    '{KIND_DRAW,  8'd0,   31'd0,          1'b1, 31'd48271},
    '{KIND_DRAW,  8'd1,   31'd0,          1'b0, 31'd0},
    '{KIND_PLANT, 8'd0,   31'd0,          1'b0, 31'd0},
    '{KIND_DRAW,  8'd0,   31'd0,          1'b1, 31'd115541394},
    '{KIND_PLANT, 8'd128, 31'h7FFF_FFFF,  1'b0, 31'd0},
    '{KIND_DRAW,  8'd128, 31'd0,          1'b0, 31'd0},
    '{KIND_PUT,   8'd255, 31'd1,          1'b0, 31'd0},
    '{KIND_DRAW,  8'd255, 31'd0,          1'b1, 31'd48271},
    '{KIND_PUT,   8'd200, 31'd0,          1'b0, 31'd0},
    '{KIND_DRAW,  8'd200, 31'd0,          1'b1, 31'd115541394},
    '{KIND_INIT,  8'd3,   31'd5,          1'b0, 31'd0},
    '{KIND_DRAW,  8'd0,   31'd0,          1'b1, 31'd241355}
  };

  logic clk;
  logic rst;

  msl_in_if  items ();
  msl_out_if samples ();

  multi_stream_lehmer_rng_core dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .samples (samples)
  );

  // Sideband that travels with the offered beat: typed-in sample, if any.
  logic   pin_on;
  state_t pin_val;

  // Own copy of the generator state.
  state_t lehmer_state [NumStreams];
  logic   streams_planted;
  state_t expected_samples [$];

  int unsigned kind_count [4];
  int unsigned samples_checked;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int          burst_left;

  // Receiver controls.
  logic        hold_req;
  logic        hold_done;
  int unsigned hold_left;
  logic [7:0]  rx_tick;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Multiply modulo the Mersenne prime 2^31-1 with a plain 64-bit remainder.
  function automatic state_t mulmod(input state_t a, input mulk_t k);
    logic [63:0] p;
    p = 64'(a) * 64'(k);
    return state_t'(p % 64'h7FFF_FFFF);
  endfunction

  // Map the seeds congruent to zero onto the default seed.
  function automatic state_t seed_fix(input state_t s);
    if (s == 31'd0 || s == 31'h7FFF_FFFF) begin
      return LehmerDefault;
    end
    return s;
  endfunction

  task automatic plant_streams(input state_t seed);
    streams_planted = 1'b1;
    lehmer_state[0] = seed;
    for (int j = 1; j < NumStreams; j++) begin
      lehmer_state[j] = mulmod(lehmer_state[j-1], LehmerJump);
    end
  endtask

  task automatic reset_streams();
    for (int j = 0; j < NumStreams; j++) begin
      lehmer_state[j] = '0;
    end
    lehmer_state[0] = LehmerDefault;
    streams_planted = 1'b0;
  endtask

  // Advance the copy by one accepted request; queue the sample a draw yields.
  task automatic apply_request(input kind_t k, input idx_t s, input state_t sd,
                               input logic pinned, input state_t pv);
    state_t nxt;
    // Touching a nonzero stream before any plant runs the default chain first.
    if ((k == KIND_DRAW || k == KIND_PUT) && !streams_planted && s != '0) begin
      plant_streams(LehmerDefault);
    end
    case (k)
      KIND_DRAW: begin
        nxt = mulmod(lehmer_state[s], LehmerMul);
        lehmer_state[s] = nxt;
        expected_samples.push_back(pinned ? pv : nxt);
      end
      KIND_PLANT: plant_streams(seed_fix(sd));
      KIND_INIT:  lehmer_state[0] = seed_fix(sd);
      default:    lehmer_state[s] = seed_fix(sd);
    endcase
    kind_count[k]++;
  endtask

  // Track every accepted request beat in order.
  always @(posedge clk) begin
    if (rst) begin
      reset_streams();
    end else if (items.valid && items.ready) begin
      apply_request(kind_t'(items.kind), items.stream, items.seed_value, pin_on, pin_val);
    end
  end

  // Compare each sample beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && samples.valid && samples.ready) begin
      if (expected_samples.size() == 0) begin
        $error("sample: expected none, actual %0d", samples.sample);
        err_cnt++;
      end else begin
        if (samples.sample !== expected_samples[0]) begin
          $error("sample: expected %0d, actual %0d", expected_samples[0], samples.sample);
          err_cnt++;
        end
        void'(expected_samples.pop_front());
        samples_checked++;
      end
    end
  end

  // Bail out on a hang.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("multi_stream_lehmer_rng_core: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: rotate through always-ready, mostly-ready, mostly-stalled and coin-flip
  // phases, picked by the top two tick bits; on request, hold off for one long stretch.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      samples.ready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
      rx_tick       <= '0;
    end else begin
      rx_tick <= rx_tick + 8'd1;
      if (hold_left != 0) begin
        samples.ready <= 1'b0;
        hold_left     <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
        samples.ready <= 1'b0;
        hold_left     <= LongHold;
        hold_done     <= 1'b1;
      end else begin
        case (rx_tick[7:6])
          2'd0:    samples.ready <= 1'b1;
          2'd1:    samples.ready <= ($urandom_range(0, 3) != 0);
          2'd2:    samples.ready <= (rx_tick[2:0] == 3'd5);
          default: samples.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one request beat and hold it until accepted. Open a new burst when
  // the current one runs out, idling a random gap first (often none).
  task automatic offer_beat(input kind_t k, input idx_t s, input state_t sd,
                            input logic pinned, input state_t pv);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        // Drop valid and scramble the payload; it must be ignored.
        items.valid      <= 1'b0;
        items.kind       <= 2'($urandom_range(0, 3));
        items.stream     <= 8'($urandom_range(0, 255));
        items.seed_value <= 31'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    items.valid      <= 1'b1;
    items.kind       <= k;
    items.stream     <= s;
    items.seed_value <= sd;
    pin_on           <= pinned;
    pin_val          <= pv;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every queued sample has come back.
  task automatic drain_samples();
    items.valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  function automatic state_t rand_seed();
    case ($urandom_range(0, 19))
      0:       return 31'd0;
      1:       return 31'h7FFF_FFFF;
      2:       return 31'h7FFF_FFFE;
      3:       return 31'd1;
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic idx_t rand_stream();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LastStream;
      default: return idx_t'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int          pick;
    kind_t       k;
    int unsigned missing;

    // Drive every input to a known value from time zero.
    rst              <= 1'b1;
    items.valid      <= 1'b0;
    items.kind       <= KIND_DRAW;
    items.stream     <= '0;
    items.seed_value <= '0;
    pin_on           <= 1'b0;
    pin_val          <= '0;
    hold_req         <= 1'b0;
    burst_left       = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    for (int i = 0; i < NDir; i++) begin
      offer_beat(DirTab[i].kind, DirTab[i].stream, DirTab[i].seed,
                 DirTab[i].pinned, DirTab[i].sample);
    end
    drain_samples();

    // Random traffic, mostly draws; plants stay rare since each runs the whole jump chain.
    for (int i = 0; i < RandItems; i++) begin
      if (i == 200) begin
        // Starve the output for a long stretch and keep pushing draws so the
        // core fills up and stalls its input.
        hold_req   <= 1'b1;
        burst_left = 40;
        for (int j = 0; j < 30; j++) begin
          offer_beat(KIND_DRAW, rand_stream(), rand_seed(), 1'b0, '0);
        end
      end
      if (i == 375) begin
        drain_samples();
      end
      pick = $urandom_range(0, 99);
      if (pick < 60)      k = KIND_DRAW;
      else if (pick < 75) k = KIND_PUT;
      else if (pick < 90) k = KIND_INIT;
      else                k = KIND_PLANT;
      offer_beat(k, rand_stream(), rand_seed(), 1'b0, '0);
    end

    // Wind down: let the last samples land, then watch for strays.
    drain_samples();
    repeat (DrainWait) @(posedge clk);
    missing = expected_samples.size();
    if (missing != 0) begin
      $error("sample: expected %0d more beats, actual 0", missing);
    end

    $display("requests: %0d draw, %0d plant, %0d init, %0d put (%0d cycles)",
             kind_count[KIND_DRAW], kind_count[KIND_PLANT], kind_count[KIND_INIT],
             kind_count[KIND_PUT], cycle_cnt);
    $display("samples compared: %0d, errors: %0d", samples_checked, err_cnt + missing);
    if (err_cnt == 0 && missing == 0) begin
      $display("multi_stream_lehmer_rng_core: match");
    end else begin
      $display("multi_stream_lehmer_rng_core: mismatch");
    end
    $finish;
  end

endmodule
